[hdl/srrc_pkg.sv]
// shared types and constants of the root-raised-cosine interpolating filter
// no dependencies; imported by srrc_interpolating_fir_unit
`default_nettype none

package srrc_pkg;

  // default sizes
  localparam int MAX_TAPS_DEF     = 256;
  localparam int MAX_SPS_DEF      = 16;
  localparam int MAX_SPAN_DEF     = 15;
  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int COEF_WIDTH_DEF   = 16;

  // register file
  localparam int SPS_W  = 5;
  localparam int SPAN_W = 4;
  localparam int CFG_W  = 5;
  localparam logic [SPS_W-1:0]  SPS_RESET  = 5'd4;
  localparam logic [SPAN_W-1:0] SPAN_RESET = 4'd8;

  typedef enum logic [0:0] {
    CFG_SPS  = 1'b0,
    CFG_SPAN = 1'b1
  } cfg_reg_t;

  // request kinds
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_PUSH = 1'b1;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_EMIT
  } srrc_state_t;

endpackage

`default_nettype wire

[hdl/srrc_interpolating_fir_unit.sv]
// top level of the root-raised-cosine interpolating filter: tap ram, symbol
// history ram, shared complex mac and output register; depends on srrc_pkg
`default_nettype none

// Usage:
//   in_* channel: one request per accepted item. in_action low writes
//   in_tap_value to tap in_tap_index (no result); high
//   pushes the complex symbol in_sym_re/in_sym_im.
//   out_* channel: a push yields sps samples, the last one with
//   out_last_sample set.
//   cfg_*: write samples_per_symbol (index 0) or span_symbols (index 1) while
//   no push is in progress.
// Sequencing: one symbol at a time through one shared complex mac reading
// both rams; each phase reads its taps, then drains the pipeline and emits
// its sample, and a new request is taken only once the last sample of a
// push has been emitted.
// Reset: history cleared through valid bits, pointer zero, sps 4, span 8;
// tap ram keeps whatever it holds and must be loaded before pushing.
// Stall: each sample sits in the output register while the next phase is
// computed; the sequencer waits before overwriting it.
module srrc_interpolating_fir_unit #(
  parameter int MAX_TAPS     = srrc_pkg::MAX_TAPS_DEF,
  parameter int MAX_SPS      = srrc_pkg::MAX_SPS_DEF,
  parameter int MAX_SPAN     = srrc_pkg::MAX_SPAN_DEF,
  parameter int SAMPLE_WIDTH = srrc_pkg::SAMPLE_WIDTH_DEF,
  parameter int COEF_WIDTH   = srrc_pkg::COEF_WIDTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  // configuration
  input  wire logic                              cfg_wr_en,
  input  wire srrc_pkg::cfg_reg_t                cfg_index,
  input  wire logic [srrc_pkg::CFG_W-1:0]        cfg_wdata,
  // input channel
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic                              in_action,
  input  wire logic [7:0]                        in_tap_index,
  input  wire logic signed [COEF_WIDTH-1:0]      in_tap_value,
  input  wire logic signed [SAMPLE_WIDTH-1:0]    in_sym_re,
  input  wire logic signed [SAMPLE_WIDTH-1:0]    in_sym_im,
  // output channel
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic signed [SAMPLE_WIDTH-1:0]         out_re,
  output logic signed [SAMPLE_WIDTH-1:0]         out_im,
  output logic                                   out_last_sample
);
  import srrc_pkg::*;

  localparam int HD       = MAX_SPAN + 1;
  localparam int HW       = $clog2(HD);
  localparam int TAW      = $clog2(MAX_TAPS);
  localparam int SPW      = $clog2(MAX_SPS + 1);
  localparam int SNW      = $clog2(MAX_SPAN + 1);
  localparam int JW       = $clog2(MAX_SPS * MAX_SPAN + MAX_SPS + 1);
  localparam int PW       = COEF_WIDTH + SAMPLE_WIDTH;
  localparam int ACC_FULL = PW + $clog2(MAX_SPAN + 2) + 1;
  localparam int ACCW     = (ACC_FULL > 64) ? 64 : ACC_FULL;
  localparam int SH       = COEF_WIDTH - 1;

  // configuration registers
  logic [SPS_W-1:0]  sps_r;
  logic [SPAN_W-1:0] span_r;

  // sequencer registers
  srrc_state_t       state_r, state_nxt;
  logic [HW-1:0]     ptr_r, ptr_nxt;
  logic [HW-1:0]     slot_r, slot_nxt;
  logic [JW-1:0]     j_r, j_nxt;
  logic [JW-1:0]     ntaps_r, ntaps_nxt;
  logic [SPW-1:0]    sps_l_r, sps_l_nxt;
  logic [SPW-1:0]    p_r, p_nxt;
  logic [HD-1:0]     hvld_r, hvld_nxt;

  // pipeline registers
  logic                          v1_r, v2_r;
  logic signed [COEF_WIDTH-1:0]  tap_rd_r;
  logic                          tap_ok_r;
  logic [2*SAMPLE_WIDTH-1:0]     hist_rd_r;
  logic                          hist_ok_r;
  logic signed [PW-1:0]          prod_re_r, prod_im_r;
  logic signed [ACCW-1:0]        acc_re_r, acc_im_r;

  // output register
  logic                          out_valid_r;
  logic signed [SAMPLE_WIDTH-1:0] out_re_r, out_im_r;
  logic                          out_last_r;

  // memories
  logic signed [COEF_WIDTH-1:0]  tap_mem [MAX_TAPS];
  logic [2*SAMPLE_WIDTH-1:0]     hist_mem [HD];

  // control strobes
  logic in_acc, load_go, push_go, issue, last_issue, emit_go, drained, last_phase;
  logic [SPW-1:0]  sps_eff;
  logic [SNW-1:0]  span_eff;
  logic [TAW-1:0]  tap_wa;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sps_r  <= SPS_RESET;
      span_r <= SPAN_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_SPS:  sps_r  <= cfg_wdata[SPS_W-1:0];
        CFG_SPAN: span_r <= cfg_wdata[SPAN_W-1:0];
        default:  ;
      endcase
    end
  end

  // clamp out-of-range settings
  always_comb begin
    if (sps_r == '0)
      sps_eff = SPW'(1);
    else if (32'(sps_r) > MAX_SPS)
      sps_eff = SPW'(MAX_SPS);
    else
      sps_eff = SPW'(sps_r);
    if (span_r == '0)
      span_eff = SNW'(1);
    else if (32'(span_r) > MAX_SPAN)
      span_eff = SNW'(MAX_SPAN);
    else
      span_eff = SNW'(span_r);
  end

  // handshake and sequencing strobes
  always_comb begin
    in_stall   = (state_r != ST_IDLE);
    issue      = (state_r == ST_RUN);
    in_acc     = in_valid && (state_r == ST_IDLE);
    load_go    = in_acc && (in_action == ACT_LOAD);
    push_go    = in_acc && (in_action == ACT_PUSH);
    last_issue = ({1'b0, j_r} + {1'b0, JW'(sps_l_r)}) >= {1'b0, ntaps_r};
    drained    = !v1_r && !v2_r;
    last_phase = ({1'b0, p_r} + 1'b1) == {1'b0, sps_l_r};
    emit_go    = (state_r == ST_EMIT) && (!out_valid_r || !out_stall);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (push_go) state_nxt = ST_RUN;
      ST_RUN:   if (last_issue) state_nxt = ST_DRAIN;
      ST_DRAIN: if (drained) state_nxt = ST_EMIT;
      ST_EMIT:  if (emit_go) state_nxt = last_phase ? ST_IDLE : ST_RUN;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // counters, pointer and history valid bits
  always_comb begin
    ptr_nxt   = ptr_r;
    slot_nxt  = slot_r;
    j_nxt     = j_r;
    ntaps_nxt = ntaps_r;
    sps_l_nxt = sps_l_r;
    p_nxt     = p_r;
    hvld_nxt  = hvld_r;
    if (push_go) begin
      ptr_nxt   = (ptr_r == HW'(HD - 1)) ? '0 : ptr_r + 1'b1;
      slot_nxt  = ptr_nxt;
      hvld_nxt[ptr_nxt] = 1'b1;
      j_nxt     = '0;
      p_nxt     = '0;
      sps_l_nxt = sps_eff;
      ntaps_nxt = JW'(32'(sps_eff) * 32'(span_eff) + 1);
    end else if (issue) begin
      j_nxt    = j_r + JW'(sps_l_r);
      slot_nxt = (slot_r == '0) ? HW'(HD - 1) : slot_r - 1'b1;
    end else if (emit_go && !last_phase) begin
      p_nxt    = p_r + 1'b1;
      j_nxt    = JW'(p_nxt);
      slot_nxt = ptr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ptr_r   <= '0;
      hvld_r  <= '0;
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ptr_r   <= ptr_nxt;
      hvld_r  <= hvld_nxt;
      v1_r    <= issue;
      v2_r    <= v1_r;
    end
    slot_r  <= slot_nxt;
    j_r     <= j_nxt;
    ntaps_r <= ntaps_nxt;
    sps_l_r <= sps_l_nxt;
    p_r     <= p_nxt;
  end

  // tap ram: load port and mac read port
  assign tap_wa = TAW'(in_tap_index);

  always_ff @(posedge clk) begin
    if (load_go && (32'(in_tap_index) < MAX_TAPS))
      tap_mem[tap_wa] <= in_tap_value;
    if (issue) begin
      tap_rd_r <= tap_mem[TAW'(j_r)];
      tap_ok_r <= (32'(j_r) < MAX_TAPS);
    end
  end

  // history ram: newest symbol written on push, read one slot per tap
  always_ff @(posedge clk) begin
    if (push_go)
      hist_mem[ptr_nxt] <= {in_sym_re, in_sym_im};
    if (issue) begin
      hist_rd_r <= hist_mem[slot_r];
      hist_ok_r <= hvld_r[slot_r];
    end
  end

  // complex multiply, real tap on both rails
  always_ff @(posedge clk) begin
    logic signed [COEF_WIDTH-1:0]   h;
    logic signed [SAMPLE_WIDTH-1:0] sr, si;
    h  = tap_ok_r ? tap_rd_r : '0;
    sr = hist_ok_r ? $signed(hist_rd_r[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH]) : '0;
    si = hist_ok_r ? $signed(hist_rd_r[SAMPLE_WIDTH-1:0]) : '0;
    if (v1_r) begin
      prod_re_r <= h * sr;
      prod_im_r <= h * si;
    end
  end

  // accumulate, cleared at the start of each phase
  always_ff @(posedge clk) begin
    if (push_go || emit_go) begin
      acc_re_r <= '0;
      acc_im_r <= '0;
    end else if (v2_r) begin
      acc_re_r <= acc_re_r + ACCW'(prod_re_r);
      acc_im_r <= acc_im_r + ACCW'(prod_im_r);
    end
  end

  // round half up, then saturate
  logic signed [ACCW-1:0]         t_re, t_im, r_re, r_im;
  logic [ACCW-SAMPLE_WIDTH:0]     hi_re, hi_im;
  logic signed [SAMPLE_WIDTH-1:0] q_re, q_im;

  always_comb begin
    t_re  = acc_re_r + (ACCW'(1) <<< (SH - 1));
    t_im  = acc_im_r + (ACCW'(1) <<< (SH - 1));
    r_re  = t_re >>> SH;
    r_im  = t_im >>> SH;
    hi_re = r_re[ACCW-1:SAMPLE_WIDTH-1];
    hi_im = r_im[ACCW-1:SAMPLE_WIDTH-1];
    if ((&hi_re) || !(|hi_re))
      q_re = r_re[SAMPLE_WIDTH-1:0];
    else
      q_re = {r_re[ACCW-1], {(SAMPLE_WIDTH-1){~r_re[ACCW-1]}}};
    if ((&hi_im) || !(|hi_im))
      q_im = r_im[SAMPLE_WIDTH-1:0];
    else
      q_im = {r_im[ACCW-1], {(SAMPLE_WIDTH-1){~r_im[ACCW-1]}}};
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n)
      out_valid_r <= 1'b0;
    else if (emit_go)
      out_valid_r <= 1'b1;
    else if (!out_stall)
      out_valid_r <= 1'b0;
    if (emit_go) begin
      out_re_r   <= q_re;
      out_im_r   <= q_im;
      out_last_r <= last_phase;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_re          = out_re_r;
  assign out_im          = out_im_r;
  assign out_last_sample = out_last_r;

  // checks
  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall |-> (!v1_r && !v2_r))
    else $error("request taken while mac pipeline busy");

  a_emit_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> (!v1_r && !v2_r))
    else $error("sample emitted before accumulation finished");

  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> (p_r < sps_l_r))
    else $error("phase counter beyond samples per symbol");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> (out_valid_r && $stable(out_re_r)
      && $stable(out_im_r)))
    else $error("pending sample overwritten");

endmodule

`default_nettype wire

[tb/tb_top.sv]
// self-checking testbench for srrc_interpolating_fir_unit: tap loads and symbol
// requests checked sample by sample against a polyphase predictor
// depends on srrc_pkg and srrc_interpolating_fir_unit
`default_nettype none

module tb_top;
  import srrc_pkg::*;

  // one input request as driven on the in_ channel
  typedef struct packed {
    logic               action;
    logic [7:0]         tap_idx;
    logic signed [15:0] tap_val;
    logic signed [15:0] sym_re;
    logic signed [15:0] sym_im;
    logic               typed;
    logic signed [15:0] want_re;
    logic signed [15:0] want_im;
  } fir_req_t;

  // one filtered output sample
  typedef struct packed {
    logic signed [15:0] re;
    logic signed [15:0] im;
    logic               last;
  } sample_t;

  // directed table row: a setting write or a request
  typedef struct packed {
    logic       is_cfg;
    cfg_reg_t   sel;
    logic [4:0] wdata;
    fir_req_t   req;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_wr_en = 1'b0;
  cfg_reg_t cfg_index = CFG_SPS;
  logic [CFG_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_action = ACT_LOAD;
  logic [7:0] in_tap_index = '0;
  logic signed [15:0] in_tap_value = '0;
  logic signed [15:0] in_sym_re = '0;
  logic signed [15:0] in_sym_im = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [15:0] out_re;
  logic signed [15:0] out_im;
  logic out_last_sample;

  srrc_interpolating_fir_unit DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_action       (in_action),
    .in_tap_index    (in_tap_index),
    .in_tap_value    (in_tap_value),
    .in_sym_re       (in_sym_re),
    .in_sym_im       (in_sym_im),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_re          (out_re),
    .out_im          (out_im),
    .out_last_sample (out_last_sample)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state: settings, taps and symbol history
  logic [4:0] sps_set = SPS_RESET;
  logic [3:0] span_set = SPAN_RESET;
  logic signed [15:0] tap_mem [256];
  logic tap_ok [256];
  logic signed [15:0] hist_re [16];
  logic signed [15:0] hist_im [16];
  logic [3:0] hist_ptr = '0;

  fir_req_t req_q [$];
  fir_req_t cur_req;
  sample_t pending_samples [$];
  dir_row_t dir_tab [$];

  int reqs_queued = 0;
  int reqs_taken = 0;
  int loads_sent = 0;
  int symbols_sent = 0;
  int results_seen = 0;
  int settings_written = 0;
  int mismatches = 0;
  int gap_left = 0;
  int burst_left = 0;
  int pat_left = 0;
  int pat_mode = 0;
  logic hold_off = 1'b0;

  initial begin
    for (int k = 0; k < 256; k++) begin
      tap_mem[k[7:0]] = '0;
      tap_ok[k[7:0]] = 1'b0;
    end
    for (int k = 0; k < 16; k++) begin
      hist_re[k[3:0]] = '0;
      hist_im[k[3:0]] = '0;
    end
  end

  function automatic int eff_sps();
    if (sps_set == 0) return 1;
    if (sps_set > 16) return 16;
    return int'(sps_set);
  endfunction

  function automatic int eff_span();
    return (span_set == 0) ? 1 : int'(span_set);
  endfunction

  // round half up by 15 bits, saturate to 16 signed bits
  function automatic logic signed [15:0] round_q15(longint acc);
    longint r;
    r = (acc + 64'sd16384) >>> 15;
    if (r > 32767) r = 32767;
    else if (r < -32768) r = -32768;
    return r[15:0];
  endfunction

  function automatic logic signed [15:0] rand_sample();
    case ($urandom_range(0, 7))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return 16'sh0000;
      default: return 16'($urandom);
    endcase
  endfunction

  // half the draws give modest taps so that not every sum saturates
  function automatic logic signed [15:0] rand_coef();
    case ($urandom_range(0, 7))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2, 3, 4, 5: return 16'($signed($urandom_range(0, 4095)) - 2048);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic dir_row_t t_cfg(cfg_reg_t sel, logic [4:0] val);
    dir_row_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.sel = sel;
    r.wdata = val;
    return r;
  endfunction

  // load request; symbol fields carry junk the block must ignore
  function automatic dir_row_t t_load(logic [7:0] idx, logic signed [15:0] val);
    dir_row_t r;
    r = '0;
    r.req.action = ACT_LOAD;
    r.req.tap_idx = idx;
    r.req.tap_val = val;
    r.req.sym_re = 16'($urandom);
    r.req.sym_im = 16'($urandom);
    return r;
  endfunction

  // symbol request; tap fields carry junk the block must ignore
  function automatic dir_row_t t_push(logic signed [15:0] re, logic signed [15:0] im);
    dir_row_t r;
    r = '0;
    r.req.action = ACT_PUSH;
    r.req.tap_idx = 8'($urandom);
    r.req.tap_val = 16'($urandom);
    r.req.sym_re = re;
    r.req.sym_im = im;
    return r;
  endfunction

  function automatic dir_row_t t_check(logic signed [15:0] re, logic signed [15:0] im,
                                       logic signed [15:0] want_re,
                                       logic signed [15:0] want_im);
    dir_row_t r;
    r = t_push(re, im);
    r.req.typed = 1'b1;
    r.req.want_re = want_re;
    r.req.want_im = want_im;
    return r;
  endfunction

  // accepted request: update taps or run the polyphase filter
  task automatic filter_model_step(fir_req_t req);
    int n_sps, n_span, n_taps, j;
    logic [3:0] slot;
    longint acc_re, acc_im;
    sample_t s;
    if (req.action == ACT_LOAD) begin
      tap_mem[req.tap_idx] = req.tap_val;
    end else begin
      n_sps = eff_sps();
      n_span = eff_span();
      n_taps = n_sps * n_span + 1;
      hist_ptr = hist_ptr + 4'd1;
      hist_re[hist_ptr] = req.sym_re;
      hist_im[hist_ptr] = req.sym_im;
      for (int p = 0; p < n_sps; p++) begin
        acc_re = 0;
        acc_im = 0;
        for (int d = 0; d <= n_span; d++) begin
          j = d * n_sps + p;
          if (j < n_taps) begin
            slot = hist_ptr - d[3:0];
            acc_re += longint'(tap_mem[j[7:0]]) * longint'(hist_re[slot]);
            acc_im += longint'(tap_mem[j[7:0]]) * longint'(hist_im[slot]);
          end
        end
        s.re = round_q15(acc_re);
        s.im = round_q15(acc_im);
        s.last = (p + 1 == n_sps);
        if (req.typed) begin
          s.re = req.want_re;
          s.im = req.want_im;
        end
        pending_samples.push_back(s);
      end
    end
  endtask

  // sender: bursts of requests with random gaps, predictor runs on acceptance
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        reqs_taken++;
        filter_model_step(cur_req);
      end
      if (!in_valid || !in_stall) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 12);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
        if (gap_left > 0 || req_q.size() == 0) begin
          if (gap_left > 0) gap_left--;
          in_valid <= 1'b0;
        end else begin
          cur_req = req_q.pop_front();
          burst_left--;
          in_valid <= 1'b1;
          in_action <= cur_req.action;
          in_tap_index <= cur_req.tap_idx;
          in_tap_value <= cur_req.tap_val;
          in_sym_re <= cur_req.sym_re;
          in_sym_im <= cur_req.sym_im;
        end
      end
    end
  end

  task automatic flag_sample(string why, sample_t want);
    mismatches++;
    if (mismatches <= 10)
      $display("%s: want re=%0d im=%0d last=%0b, got re=%0d im=%0d last=%0b",
               why, want.re, want.im, want.last, out_re, out_im, out_last_sample);
  endtask

  // receiver: stall pattern of its own, check each accepted sample
  always @(posedge clk) begin
    sample_t want;
    logic s;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (pending_samples.size() == 0) begin
          flag_sample("unexpected sample", '0);
        end else begin
          want = pending_samples.pop_front();
          if (out_re !== want.re || out_im !== want.im || out_last_sample !== want.last)
            flag_sample("sample mismatch", want);
        end
      end
      if (pat_left == 0) begin
        pat_mode = $urandom_range(0, 3);
        pat_left = $urandom_range(16, 96);
      end else begin
        pat_left--;
      end
      case (pat_mode)
        0: s = 1'b0;
        1: s = ($urandom_range(0, 3) == 0);
        2: s = ($urandom_range(0, 3) != 0);
        default: s = ~out_stall;
      endcase
      out_stall <= hold_off | s;
    end
  end

  // long receiver hold-off so the block backs up into its input
  initial begin
    int thr;
    thr = 150;
    repeat (2) begin
      wait (results_seen >= thr);
      @(posedge clk);
      hold_off <= 1'b1;
      repeat (600) @(posedge clk);
      hold_off <= 1'b0;
      thr = 800;
    end
  end

  task automatic queue_request(fir_req_t r);
    req_q.push_back(r);
    reqs_queued++;
    if (r.action == ACT_LOAD) begin
      tap_ok[r.tap_idx] = 1'b1;
      loads_sent++;
    end else begin
      symbols_sent++;
    end
  endtask

  // wait until every request is taken and every sample is back
  task automatic settle(int cycles);
    while (reqs_taken != reqs_queued || pending_samples.size() != 0) @(posedge clk);
    repeat (cycles) @(posedge clk);
  endtask

  task automatic write_setting(cfg_reg_t sel, logic [4:0] val);
    settle(16);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= sel;
    cfg_wdata <= val;
    if (sel == CFG_SPS) sps_set = val;
    else span_set = val[3:0];
    settings_written++;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // load every tap the current setting reads that was never written
  task automatic fill_taps();
    int n;
    dir_row_t r;
    n = eff_sps() * eff_span() + 1;
    for (int k = 0; k < n; k++) begin
      if (!tap_ok[k[7:0]]) begin
        r = t_load(k[7:0], rand_coef());
        queue_request(r.req);
      end
    end
  endtask

  // main stimulus
  initial begin
    dir_row_t r;
    int n, new_sps, new_span;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // taps for the reset setting, then the directed table
    fill_taps();
    dir_tab.push_back(t_push(16'sh1234, 16'shEDCC));
    dir_tab.push_back(t_push(16'sh8000, 16'sh7FFF));
    dir_tab.push_back(t_cfg(CFG_SPS, 5'd1));
    dir_tab.push_back(t_cfg(CFG_SPAN, 5'd1));
    dir_tab.push_back(t_load(8'd0, 16'sh8000));
    dir_tab.push_back(t_load(8'd1, 16'sh0000));
    // minus one times the most negative input saturates
    dir_tab.push_back(t_check(16'sh8000, 16'sh7FFF, 16'sh7FFF, -16'sd32767));
    dir_tab.push_back(t_check(16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000));
    dir_tab.push_back(t_check(16'sh7FFF, 16'sh8000, -16'sd32767, 16'sh7FFF));
    // a half rounds up on both signs
    dir_tab.push_back(t_load(8'd0, 16'sh4000));
    dir_tab.push_back(t_check(16'sh0001, -16'sd1, 16'sh0001, 16'sh0000));
    dir_tab.push_back(t_load(8'd255, 16'sh7FFF));
    dir_tab.push_back(t_load(8'd1, 16'sh7FFF));
    dir_tab.push_back(t_load(8'd0, 16'sh7FFF));
    dir_tab.push_back(t_push(16'sh7FFF, 16'sh7FFF));
    dir_tab.push_back(t_push(16'sh8000, 16'sh8000));
    // zero settings act as one
    dir_tab.push_back(t_cfg(CFG_SPS, 5'd0));
    dir_tab.push_back(t_cfg(CFG_SPAN, 5'd0));
    dir_tab.push_back(t_push(16'sh0001, -16'sd1));
    dir_tab.push_back(t_push(-16'sd1, 16'sh0001));
    dir_tab.push_back(t_cfg(CFG_SPS, 5'd2));
    dir_tab.push_back(t_cfg(CFG_SPAN, 5'd1));
    dir_tab.push_back(t_push(16'sh4000, -16'sd16384));
    dir_tab.push_back(t_load(8'd2, 16'sh8000));
    dir_tab.push_back(t_push(16'sh8000, 16'sh7FFF));
    foreach (dir_tab[i]) begin
      if (dir_tab[i].is_cfg) write_setting(dir_tab[i].sel, dir_tab[i].wdata);
      else queue_request(dir_tab[i].req);
    end

    // random phases: extreme settings first, then a fixed middle one, then random ones
    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: begin new_sps = 31; new_span = 15; end
        1: begin new_sps = 1;  new_span = 15; end
        2: begin new_sps = 16; new_span = 1;  end
        3: begin new_sps = 0;  new_span = 0;  end
        4: begin new_sps = 2;  new_span = 3;  end
        default: begin
          new_sps = $urandom_range(0, 31);
          new_span = $urandom_range(0, 15);
        end
      endcase
      write_setting(CFG_SPS, new_sps[4:0]);
      // the top data bit is outside the span register
      write_setting(CFG_SPAN, {1'($urandom_range(0, 1)), new_span[3:0]});
      fill_taps();
      n = eff_sps() * eff_span() + 1;
      repeat (16) begin
        if ($urandom_range(0, 4) == 0) begin
          if ($urandom_range(0, 1) == 1) r = t_load(8'($urandom_range(0, n - 1)), rand_coef());
          else r = t_load(8'($urandom_range(0, 255)), rand_coef());
        end else begin
          r = t_push(rand_sample(), rand_sample());
        end
        queue_request(r.req);
      end
    end

    settle(400);
    $display("covered %0d tap writes and %0d symbols over %0d setting writes",
             loads_sent, symbols_sent, settings_written);
    $display("checked %0d output samples, %0d mismatches", results_seen, mismatches);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // run limit
  initial begin
    #10_000_000;
    $display("timeout with %0d samples outstanding", pending_samples.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule

`default_nettype wire

[files.f]
hdl/srrc_pkg.sv
hdl/srrc_interpolating_fir_unit.sv
tb/tb_top.sv
